/* rtl/fpcu_pkg.sv */
// Shared constants for the FTRL-proximal coordinate update block.
package fpcu_pkg;

  localparam int NUM_FEATURES_DEF = 64;
  localparam int Q_FRAC = 24;
  localparam int WORD_W = 32;
  localparam int WIDE_W = 64;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] CFG_STEP_ALPHA = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_STEP_BETA = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_L1_OFFDIAG = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_L2_OFFDIAG = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_L1_DIAG = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_L2_DIAG = 3'd5;

  localparam logic [WORD_W-1:0] ALPHA_RESET = 32'd16777;
  localparam logic [WORD_W-1:0] BETA_RESET = 32'd16777;

endpackage

/* rtl/ftrl_proximal_coordinate_update_top.sv */
// FTRL-proximal per-coordinate update: sequencer, accumulator memories and config.
// A request is accepted only in idle and its result waits while out_stall is high; two
// 32-step square roots, three 64-step divisions and two 32-step multiplies run in turn
// on shared bit-serial units. Inside the L1 band two divisions are skipped, a zero
// step_alpha skips the divisions by it, and an out-of-range index goes straight to output.
// After reset a clearing pass zeroes every entry of the memories.
module ftrl_proximal_coordinate_update_top #(
  parameter int NUM_FEATURES = fpcu_pkg::NUM_FEATURES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [5:0]                          row_index,
  input  logic [5:0]                          col_index,
  input  logic signed [31:0]                  gradient,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  weight,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpcu_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [fpcu_pkg::WORD_W-1:0]         cfg_data
);
  localparam int DEPTH = NUM_FEATURES * NUM_FEATURES;
  localparam int AW = $clog2(DEPTH);
  localparam int QF = fpcu_pkg::Q_FRAC;
  localparam int W = fpcu_pkg::WORD_W;
  localparam int WW = fpcu_pkg::WIDE_W;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SQO_GO, ST_SQO_W, ST_WGT, ST_DQ_GO, ST_DQ_W,
    ST_DEN, ST_DW_GO, ST_DW_W, ST_WSET, ST_G2_GO, ST_G2_W, ST_SQN_GO, ST_SQN_W,
    ST_DS_GO, ST_DS_W, ST_SW_GO, ST_SW_W, ST_UPD, ST_PUT
  } state_t;

  state_t state;

  logic [W-1:0] step_alpha, step_beta, l1_offdiag, l2_offdiag, l1_diag, l2_diag;

  logic [W-1:0] z_mem [DEPTH];
  logic [W-1:0] n_mem [DEPTH];
  logic [W-1:0] z_rd, n_rd;
  logic [AW-1:0] addr, clr_cnt;
  logic          mem_we;
  logic [AW-1:0] mem_addr;

  logic          diag, oor;
  logic [W-1:0]  g_q;
  logic [W-1:0]  sq_old, sq_new, wm32, w_q, wmag, sigma, n_new, z_new;
  logic [WW-1:0] den;
  logic [39:0]   swm;

  logic [31:0]   idx_full;
  logic [W-1:0]  l1_sel, l2_sel, zabs, gabs, mag, sq_diff;
  logic          band, can_put;
  logic [W:0]    beta_sq;
  logic [40:0]   n_sum;
  logic [41:0]   zx, gx, swx, z_sum;

  logic          sq_start, sq_done;
  logic [WW-1:0] sq_rad;
  logic [W-1:0]  sq_res;
  logic          dv_start, dv_done;
  logic [WW-1:0] dv_dvd, dv_dsr, dv_q;
  logic          ml_start, ml_done;
  logic [W-1:0]  ml_a, ml_b;
  logic [WW-1:0] ml_p;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign can_put = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_alpha <= fpcu_pkg::ALPHA_RESET;
      step_beta <= fpcu_pkg::BETA_RESET;
      l1_offdiag <= '0;
      l2_offdiag <= '0;
      l1_diag <= '0;
      l2_diag <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpcu_pkg::CFG_STEP_ALPHA: step_alpha <= cfg_data;
        fpcu_pkg::CFG_STEP_BETA: step_beta <= cfg_data;
        fpcu_pkg::CFG_L1_OFFDIAG: l1_offdiag <= cfg_data;
        fpcu_pkg::CFG_L2_OFFDIAG: l2_offdiag <= cfg_data;
        fpcu_pkg::CFG_L1_DIAG: l1_diag <= cfg_data;
        fpcu_pkg::CFG_L2_DIAG: l2_diag <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mem_we = (state == ST_CLEAR) || (state == ST_PUT && can_put && !oor);
  assign mem_addr = (state == ST_CLEAR) ? clr_cnt : addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      z_mem[mem_addr] <= (state == ST_CLEAR) ? '0 : z_new;
      n_mem[mem_addr] <= (state == ST_CLEAR) ? '0 : n_new;
    end
    z_rd <= z_mem[addr];
    n_rd <= n_mem[addr];
  end

  always_comb begin
    idx_full = 32'(row_index) * 32'(NUM_FEATURES) + 32'(col_index);
    l1_sel = diag ? l1_diag : l1_offdiag;
    l2_sel = diag ? l2_diag : l2_offdiag;
    zabs = z_rd[W-1] ? (~z_rd + 1'b1) : z_rd;
    gabs = g_q[W-1] ? (~g_q + 1'b1) : g_q;
    band = zabs <= l1_sel;
    mag = zabs - l1_sel;
    beta_sq = {1'b0, step_beta} + {1'b0, sq_old};
    sq_diff = sq_new - sq_old;
    n_sum = {9'b0, n_rd} + {1'b0, ml_p[WW-1:QF]};
    zx = {{10{z_rd[W-1]}}, z_rd};
    gx = {{10{g_q[W-1]}}, g_q};
    swx = {2'b00, swm};
    z_sum = w_q[W-1] ? (zx + gx + swx) : (zx + gx - swx);
  end

  // Operand selection for the shared serial units.
  always_comb begin
    sq_start = (state == ST_SQO_GO) || (state == ST_SQN_GO);
    sq_rad = (state == ST_SQO_GO) ? {n_rd, 24'b0} : {n_new, 24'b0};
    dv_start = (state == ST_DQ_GO) || (state == ST_DW_GO) || (state == ST_DS_GO);
    dv_dvd = {8'b0, sq_diff, 24'b0};
    dv_dsr = {32'b0, step_alpha};
    if (state == ST_DQ_GO) begin
      dv_dvd = {7'b0, beta_sq, 24'b0};
    end else if (state == ST_DW_GO) begin
      dv_dvd = {8'b0, mag, 24'b0};
      dv_dsr = den;
    end
    ml_start = (state == ST_G2_GO) || (state == ST_SW_GO);
    ml_a = (state == ST_G2_GO) ? gabs : sigma;
    ml_b = (state == ST_G2_GO) ? gabs : wmag;
  end

  fpcu_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_res)
  );

  fpcu_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_dvd), .divisor(dv_dsr),
    .done(dv_done), .quotient(dv_q)
  );

  fpcu_mul u_mul (
    .clk(clk), .rst(rst), .start(ml_start), .op_a(ml_a), .op_b(ml_b),
    .done(ml_done), .product(ml_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_PUT && can_put) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            diag <= row_index == col_index;
            oor <= (32'(row_index) >= 32'(NUM_FEATURES)) ||
                   (32'(col_index) >= 32'(NUM_FEATURES));
            addr <= idx_full[AW-1:0];
            g_q <= gradient;
            w_q <= '0;
            wmag <= '0;
            if ((32'(row_index) >= 32'(NUM_FEATURES)) ||
                (32'(col_index) >= 32'(NUM_FEATURES))) begin
              state <= ST_PUT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: state <= ST_SQO_GO;
        ST_SQO_GO: state <= ST_SQO_W;
        ST_SQO_W: begin
          if (sq_done) begin
            sq_old <= sq_res;
            state <= ST_WGT;
          end
        end
        ST_WGT: begin
          if (band) begin
            state <= ST_G2_GO;
          end else if (step_alpha == '0) begin
            den <= {1'b0, {(WW-1){1'b1}}} + {32'b0, l2_sel};
            state <= ST_DEN;
          end else begin
            state <= ST_DQ_GO;
          end
        end
        ST_DQ_GO: state <= ST_DQ_W;
        ST_DQ_W: begin
          if (dv_done) begin
            den <= dv_q + {32'b0, l2_sel};
            state <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (den == '0) begin
            wm32 <= '1;
            state <= ST_WSET;
          end else begin
            state <= ST_DW_GO;
          end
        end
        ST_DW_GO: state <= ST_DW_W;
        ST_DW_W: begin
          if (dv_done) begin
            wm32 <= (|dv_q[WW-1:W]) ? '1 : dv_q[W-1:0];
            state <= ST_WSET;
          end
        end
        ST_WSET: begin
          // A positive z gives a negative weight and the other way round.
          if (!z_rd[W-1]) begin
            w_q <= wm32[W-1] ? 32'h8000_0000 : (~wm32 + 1'b1);
            wmag <= wm32[W-1] ? 32'h8000_0000 : wm32;
          end else begin
            w_q <= wm32[W-1] ? 32'h7FFF_FFFF : wm32;
            wmag <= wm32[W-1] ? 32'h7FFF_FFFF : wm32;
          end
          state <= ST_G2_GO;
        end
        ST_G2_GO: state <= ST_G2_W;
        ST_G2_W: begin
          if (ml_done) begin
            n_new <= (|n_sum[40:W]) ? '1 : n_sum[W-1:0];
            state <= ST_SQN_GO;
          end
        end
        ST_SQN_GO: state <= ST_SQN_W;
        ST_SQN_W: begin
          if (sq_done) begin
            sq_new <= sq_res;
            if (step_alpha == '0) begin
              sigma <= '1;
              state <= ST_SW_GO;
            end else begin
              state <= ST_DS_GO;
            end
          end
        end
        ST_DS_GO: state <= ST_DS_W;
        ST_DS_W: begin
          if (dv_done) begin
            sigma <= (|dv_q[WW-1:W]) ? '1 : dv_q[W-1:0];
            state <= ST_SW_GO;
          end
        end
        ST_SW_GO: state <= ST_SW_W;
        ST_SW_W: begin
          if (ml_done) begin
            swm <= ml_p[WW-1:QF];
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (z_sum[41:W-1] == '0 || z_sum[41:W-1] == '1) begin
            z_new <= z_sum[W-1:0];
          end else begin
            z_new <= z_sum[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
          state <= ST_PUT;
        end
        ST_PUT: begin
          if (can_put) begin
            weight <= w_q;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* rtl/fpcu_sqrt.sv */
// Bit-serial restoring square root: one root bit per cycle.
module fpcu_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fpcu_pkg::WIDE_W-1:0]   radicand,
  output logic                          done,
  output logic [fpcu_pkg::WORD_W-1:0]   root
);
  localparam int RW = fpcu_pkg::WORD_W + 2;
  localparam int SW = fpcu_pkg::WORD_W + 4;
  localparam int NSTEP = fpcu_pkg::WIDE_W / 2;
  localparam int CNW = $clog2(NSTEP);

  logic               busy;
  logic [CNW-1:0]     cnt;
  logic [fpcu_pkg::WIDE_W-1:0] rad;
  logic [RW-1:0]      rem;
  logic [SW-1:0]      rem_sh;
  logic [SW-1:0]      trial;
  logic               ge;
  logic [SW-1:0]      diff;

  always_comb begin
    rem_sh = {rem, rad[fpcu_pkg::WIDE_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    ge = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
      rad <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[fpcu_pkg::WIDE_W-3:0], 2'b00};
      rem <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      root <= {root[fpcu_pkg::WORD_W-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CNW'(NSTEP - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

/* rtl/fpcu_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module fpcu_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fpcu_pkg::WIDE_W-1:0]   dividend,
  input  logic [fpcu_pkg::WIDE_W-1:0]   divisor,
  output logic                          done,
  output logic [fpcu_pkg::WIDE_W-1:0]   quotient
);
  localparam int W = fpcu_pkg::WIDE_W;
  localparam int CNW = $clog2(W);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [W-1:0]   dsr;
  logic [W-1:0]   rem;
  logic [W:0]     rem_sh;
  logic           ge;
  logic [W:0]     diff;

  always_comb begin
    rem_sh = {rem, quotient[W-1]};
    ge = rem_sh >= {1'b0, dsr};
    diff = rem_sh - {1'b0, dsr};
  end

  // The quotient bits shift in behind the dividend bits as they leave.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
      quotient <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quotient <= {quotient[W-2:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == CNW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

/* rtl/fpcu_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module fpcu_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fpcu_pkg::WORD_W-1:0]   op_a,
  input  logic [fpcu_pkg::WORD_W-1:0]   op_b,
  output logic                          done,
  output logic [fpcu_pkg::WIDE_W-1:0]   product
);
  localparam int W = fpcu_pkg::WORD_W;
  localparam int CNW = $clog2(W);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [W-1:0]   a_q;
  logic [W-1:0]   b_q;
  logic [W:0]     sum;

  always_comb begin
    sum = {1'b0, product[2*W-1:W]} + {1'b0, (b_q[0] ? a_q : '0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt <= '0;
      a_q <= op_a;
      b_q <= op_b;
      product <= '0;
    end else if (busy) begin
      product <= {sum, product[W-1:1]};
      b_q <= {1'b0, b_q[W-1:1]};
      cnt <= cnt + 1'b1;
      if (cnt == CNW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
